// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset
`define RCPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset
`define RCPS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/core/rcps_pkg.sv -----
// ----------------------------------------------------------------------------
// rcps_pkg
// Widths, codes and beat structures of the raycast column pixel shader.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcps_pkg;

    // Field widths
    localparam int COL_W     = 12;
    localparam int ROW_W     = 9;
    localparam int WALL_W    = 16;
    localparam int FACE_W    = 2;
    localparam int TCOL_W    = 12;
    localparam int TDIM_W    = 13;
    localparam int ADDR_W    = 32;
    localparam int COLOR_W   = 32;
    localparam int TEXEL_W   = 24;
    localparam int REGION_W  = 2;
    localparam int STRIDE_W  = 16;
    localparam int PBITS_W   = 6;
    localparam int BPP_W     = PBITS_W - 3;
    localparam int CFG_IDX_W = 3;

    // Texture row and divider widths
    localparam int TY_W   = TDIM_W;
    localparam int PROD_W = WALL_W + TDIM_W;
    // Signed width for row/wall geometry (half screen height up to 2048)
    localparam int SGN_W  = 18;

    // Region codes
    localparam logic [REGION_W-1:0] REGION_CEILING = 2'd0;
    localparam logic [REGION_W-1:0] REGION_WALL    = 2'd1;
    localparam logic [REGION_W-1:0] REGION_FLOOR   = 2'd2;

    // How the texture row is formed
    localparam logic [1:0] TY_DIV  = 2'd0;   // quotient of the divider
    localparam logic [1:0] TY_LAST = 2'd1;   // tex_height - 1
    localparam logic [1:0] TY_ZERO = 2'd2;   // zero texture height

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CEILING_COLOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR_COLOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_BITS    = 3'd4;

    // Register reset values
    localparam logic [STRIDE_W-1:0] LINE_STRIDE_RST = 16'd2048;
    localparam logic [PBITS_W-1:0]  PIXEL_BITS_RST  = 6'd32;

    // Configuration registers
    typedef struct packed {
        logic [COLOR_W-1:0]  ceiling_color;
        logic [COLOR_W-1:0]  floor_color;
        logic [ADDR_W-1:0]   frame_base;
        logic [STRIDE_W-1:0] line_stride;
        logic [PBITS_W-1:0]  pixel_bits;
    } rcps_cfg_t;

    // Divider working set
    typedef struct packed {
        logic [PROD_W-1:0] rem;
        logic [WALL_W-1:0] divisor;
        logic [TY_W-1:0]   quot;
    } rcps_div_t;

    // Fields that ride alongside the divider
    typedef struct packed {
        logic [ADDR_W-1:0]   addr;
        logic [REGION_W-1:0] region;
        logic [COLOR_W-1:0]  flat_color;
        logic [FACE_W-1:0]   face;
        logic [TDIM_W-1:0]   tex_width;
        logic [TCOL_W-1:0]   tex_col;
        logic [TDIM_W-1:0]   tex_height;
        logic [1:0]          ty_mode;
    } rcps_side_t;

endpackage

// ----- rtl/core/rcps_classify.sv -----
// ----------------------------------------------------------------------------
// rcps_classify
// Two stages: region decision, address partial products and texture row
// setup, then address sum and divider dividend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcps_classify
    import rcps_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 512
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rcps_cfg_t           cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [COL_W-1:0]    column,
    input  logic [ROW_W-1:0]    row,
    input  logic [WALL_W-1:0]   wall_height,
    input  logic [FACE_W-1:0]   face,
    input  logic [TCOL_W-1:0]   tex_col,
    input  logic [TDIM_W-1:0]   tex_width,
    input  logic [TDIM_W-1:0]   tex_height,
    output logic                out_valid,
    input  logic                out_ready,
    output rcps_div_t           out_div,
    output rcps_side_t          out_side
);

    localparam logic signed [SGN_W-1:0] HALF_H = SGN_W'(SCREEN_HEIGHT / 2);

    typedef struct packed {
        logic [WALL_W-1:0]         d;
        logic [WALL_W-1:0]         wall;
        logic [ROW_W+STRIDE_W-1:0] row_prod;
        logic [COL_W+BPP_W-1:0]    col_prod;
        rcps_side_t                side;
    } s1_t;

    logic signed [SGN_W-1:0] half_w;
    logic signed [SGN_W-1:0] row_s;
    logic signed [SGN_W-1:0] wall_s;
    logic signed [SGN_W-1:0] c_val;
    logic signed [SGN_W-1:0] start;
    logic signed [SGN_W-1:0] wall_end;
    logic signed [SGN_W-1:0] d_s;
    logic                    c_pos;
    logic                    is_ceil;
    logic                    is_wall;
    logic [WALL_W-1:0]       d_val;
    s1_t                     s1_next;

    logic s1_valid_reg;
    s1_t  s1_reg;
    logic s1_ready;
    logic s2_ready;
    logic s2_valid_reg;
    rcps_div_t  div_reg;
    rcps_side_t side_reg;
    rcps_div_t  div_next;
    rcps_side_t side_next;

    // Geometry of the column
    assign half_w   = {{(SGN_W-WALL_W+1){1'b0}}, wall_height[WALL_W-1:1]};
    assign row_s    = {{(SGN_W-ROW_W){1'b0}}, row};
    assign wall_s   = {{(SGN_W-WALL_W){1'b0}}, wall_height};
    assign c_val    = HALF_H - half_w;
    assign c_pos    = !c_val[SGN_W-1] && (c_val != '0);
    assign is_ceil  = c_pos && (row_s <= c_val);
    assign start    = c_pos ? (c_val + SGN_W'(1)) : '0;
    assign wall_end = start + wall_s;
    assign is_wall  = !is_ceil && (row_s <= wall_end);
    assign d_s      = row_s - c_val;
    assign d_val    = d_s[SGN_W-1] ? '0 : d_s[WALL_W-1:0];

    // Stage 1 payload
    always_comb
    begin
        s1_next.d        = d_val;
        s1_next.wall     = wall_height;
        s1_next.row_prod = row * cfg.line_stride;
        s1_next.col_prod = column * cfg.pixel_bits[PBITS_W-1:3];
        s1_next.side.addr       = '0;
        s1_next.side.face       = face;
        s1_next.side.tex_width  = tex_width;
        s1_next.side.tex_col    = tex_col;
        s1_next.side.tex_height = tex_height;
        if (is_ceil)
        begin
            s1_next.side.region     = REGION_CEILING;
            s1_next.side.flat_color = cfg.ceiling_color;
        end
        else if (is_wall)
        begin
            s1_next.side.region     = REGION_WALL;
            s1_next.side.flat_color = '0;
        end
        else
        begin
            s1_next.side.region     = REGION_FLOOR;
            s1_next.side.flat_color = cfg.floor_color;
        end
        // texture row mode: past the wall end the quotient saturates
        if (tex_height == '0)
            s1_next.side.ty_mode = TY_ZERO;
        else if ((wall_height == '0) || (d_val >= wall_height))
            s1_next.side.ty_mode = TY_LAST;
        else
            s1_next.side.ty_mode = TY_DIV;
    end

    // Stage 2 payload
    always_comb
    begin
        side_next      = s1_reg.side;
        side_next.addr = cfg.frame_base + ADDR_W'(s1_reg.row_prod)
                       + ADDR_W'(s1_reg.col_prod);
        div_next.rem     = s1_reg.d * s1_reg.side.tex_height;
        div_next.divisor = s1_reg.wall;
        div_next.quot    = '0;
    end

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
            s1_reg <= s1_next;
        if (s1_valid_reg && s2_ready)
        begin
            div_reg  <= div_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/core/rcps_div_step.sv -----
// ----------------------------------------------------------------------------
// rcps_div_step
// One restoring division step: decides one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcps_div_step
    import rcps_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  rcps_div_t  in_div,
    input  rcps_side_t in_side,
    output logic       out_valid,
    input  logic       out_ready,
    output rcps_div_t  out_div,
    output rcps_side_t out_side
);

    logic [PROD_W-1:0] shifted;
    logic              take;
    rcps_div_t         div_next;
    logic              valid_reg;
    rcps_div_t         div_reg;
    rcps_side_t        side_reg;

    // Trial subtract of the shifted divisor
    assign shifted = PROD_W'(in_div.divisor) << SHIFT;
    assign take    = (in_div.rem >= shifted);

    always_comb
    begin
        div_next             = in_div;
        div_next.rem         = take ? (in_div.rem - shifted) : in_div.rem;
        div_next.quot[SHIFT] = take;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            div_reg  <= div_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ----- rtl/core/rcps_texel.sv -----
// ----------------------------------------------------------------------------
// rcps_texel
// Texture row select and texel index: multiply stage, then add and output
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcps_texel
    import rcps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rcps_div_t            in_div,
    input  rcps_side_t           in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    pixel_address,
    output logic [REGION_W-1:0]  region,
    output logic [COLOR_W-1:0]   flat_color,
    output logic [TEXEL_W-1:0]   texel_index,
    output logic [FACE_W-1:0]    texture_face
);

    localparam int MUL_W = TDIM_W + TY_W;

    logic [TY_W-1:0]   ty;
    logic              m_valid_reg;
    logic [MUL_W-1:0]  m_prod_reg;
    rcps_side_t        m_side_reg;
    logic              m_ready;
    logic              o_ready;
    logic [MUL_W-1:0]  sum;
    logic              o_valid_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [REGION_W-1:0] region_reg;
    logic [COLOR_W-1:0]  color_reg;
    logic [TEXEL_W-1:0]  texel_reg;
    logic [TEXEL_W-1:0]  texel_next;
    logic [FACE_W-1:0]   face_reg;

    // Texture row after clamping
    always_comb
    begin
        case (in_side.ty_mode)
            TY_DIV:  ty = in_div.quot;
            TY_LAST: ty = in_side.tex_height - TY_W'(1);
            default: ty = '0;
        endcase
    end

    // Row offset plus column, masked to index width; flat pixels read zero
    assign sum        = m_prod_reg + MUL_W'(m_side_reg.tex_col);
    assign texel_next = (m_side_reg.region == REGION_WALL) ? sum[TEXEL_W-1:0] : '0;

    assign o_ready  = !o_valid_reg || out_ready;
    assign m_ready  = !m_valid_reg || o_ready;
    assign in_ready = m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_ready)
                m_valid_reg <= in_valid;
            if (o_ready)
                o_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && m_ready)
        begin
            m_prod_reg <= in_side.tex_width * ty;
            m_side_reg <= in_side;
        end
        if (m_valid_reg && o_ready)
        begin
            addr_reg   <= m_side_reg.addr;
            region_reg <= m_side_reg.region;
            color_reg  <= m_side_reg.flat_color;
            texel_reg  <= texel_next;
            face_reg   <= m_side_reg.face;
        end
    end

    assign out_valid     = o_valid_reg;
    assign pixel_address = addr_reg;
    assign region        = region_reg;
    assign flat_color    = color_reg;
    assign texel_index   = texel_reg;
    assign texture_face  = face_reg;

endmodule

// ----- rtl/core/raycast_column_pixel_shader_core.sv -----
// Path: a pixel beat passes 2 classify stages, one stage per texture row
// bit in the divider, then 2 texel stages, each of them registered.
// Throughput: one pixel per cycle while out_ready is not held low; the 13-step divider is fully pipelined.
// Stalls back up stage by stage, so empty stages still take new beats.
// Reset: all valid bits clear; configuration registers return to their reset values.
// ----------------------------------------------------------------------------
// raycast_column_pixel_shader_core
// Per-pixel ceiling/wall/floor shading, texel index and framebuffer address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module raycast_column_pixel_shader_core
    import rcps_pkg::*;
#(
    parameter int SCREEN_HEIGHT = 512
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    // pixel in
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [COL_W-1:0]     column,
    input  logic [ROW_W-1:0]     row,
    input  logic [WALL_W-1:0]    wall_height,
    input  logic [FACE_W-1:0]    face,
    input  logic [TCOL_W-1:0]    tex_col,
    input  logic [TDIM_W-1:0]    tex_width,
    input  logic [TDIM_W-1:0]    tex_height,
    // pixel out
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ADDR_W-1:0]    pixel_address,
    output logic [REGION_W-1:0]  region,
    output logic [COLOR_W-1:0]   flat_color,
    output logic [TEXEL_W-1:0]   texel_index,
    output logic [FACE_W-1:0]    texture_face
);

    rcps_cfg_t  cfg_reg;
    logic       stage_valid [0:TY_W];
    logic       stage_ready [0:TY_W];
    rcps_div_t  stage_div   [0:TY_W];
    rcps_side_t stage_side  [0:TY_W];
    logic       out_beat;
    logic       out_wall_beat;
    logic       out_flat_beat;

    // Configuration registers, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ceiling_color <= '0;
            cfg_reg.floor_color   <= '0;
            cfg_reg.frame_base    <= '0;
            cfg_reg.line_stride   <= LINE_STRIDE_RST;
            cfg_reg.pixel_bits    <= PIXEL_BITS_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CEILING_COLOR: cfg_reg.ceiling_color <= cfg_data[COLOR_W-1:0];
                REG_FLOOR_COLOR:   cfg_reg.floor_color   <= cfg_data[COLOR_W-1:0];
                REG_FRAME_BASE:    cfg_reg.frame_base    <= cfg_data[ADDR_W-1:0];
                REG_LINE_STRIDE:   cfg_reg.line_stride   <= cfg_data[STRIDE_W-1:0];
                REG_PIXEL_BITS:    cfg_reg.pixel_bits    <= cfg_data[PBITS_W-1:0];
                default: ;
            endcase
        end
    end

    // Region, address and dividend
    rcps_classify #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_classify (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .column      (column),
        .row         (row),
        .wall_height (wall_height),
        .face        (face),
        .tex_col     (tex_col),
        .tex_width   (tex_width),
        .tex_height  (tex_height),
        .out_valid   (stage_valid[0]),
        .out_ready   (stage_ready[0]),
        .out_div     (stage_div[0]),
        .out_side    (stage_side[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar k = 0; k < TY_W; k++)
    begin : g_div
        rcps_div_step #(
            .SHIFT (TY_W - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[k]),
            .in_ready  (stage_ready[k]),
            .in_div    (stage_div[k]),
            .in_side   (stage_side[k]),
            .out_valid (stage_valid[k+1]),
            .out_ready (stage_ready[k+1]),
            .out_div   (stage_div[k+1]),
            .out_side  (stage_side[k+1])
        );
    end

    // Texel index and output register
    rcps_texel u_texel (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (stage_valid[TY_W]),
        .in_ready      (stage_ready[TY_W]),
        .in_div        (stage_div[TY_W]),
        .in_side       (stage_side[TY_W]),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .region        (region),
        .flat_color    (flat_color),
        .texel_index   (texel_index),
        .texture_face  (texture_face)
    );

    // Checks
    assign out_beat      = out_valid && out_ready;
    assign out_wall_beat = out_valid && (region == REGION_WALL);
    assign out_flat_beat = out_valid && (region != REGION_WALL);

    `RCPS_ASSERT_NEVER(a_region_code, out_valid && (region > REGION_FLOOR), "bad region code")
    `RCPS_ASSERT(a_flat_no_texel, out_flat_beat |-> (texel_index == '0), "texel on flat pixel")
    `RCPS_ASSERT(a_wall_no_color, out_wall_beat |-> (flat_color == '0), "color on wall pixel")
    `RCPS_ASSERT(a_drain, out_beat |=> (in_ready || out_valid), "pipe stuck after drain")

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the column pixel shader. Pixel beats go in with
// random gaps, results come out under random back-pressure. Each accepted
// pixel is shaded by a local model (or given its listed shade) and queued.
// Results that come out are checked field by field, oldest first. The
// registers are rewritten between runs of pixels, once the pipe has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rcps_pkg::*;

    localparam int     SCREEN_H     = 512;
    localparam longint HALF_H       = SCREEN_H / 2;
    localparam int     LIMIT_CYCLES = 300000;
    localparam int     PHASE_PIXELS = 210;
    localparam int     PHASE_COUNT  = 8;
    localparam int     DRAIN_CYCLES = 40;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // One pixel beat in, one shaded beat out
    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [WALL_W-1:0] wall_height;
        logic [FACE_W-1:0] face;
        logic [TCOL_W-1:0] tex_col;
        logic [TDIM_W-1:0] tex_width;
        logic [TDIM_W-1:0] tex_height;
    } pixel_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   pixel_address;
        logic [REGION_W-1:0] region;
        logic [COLOR_W-1:0]  flat_color;
        logic [TEXEL_W-1:0]  texel_index;
        logic [FACE_W-1:0]   texture_face;
    } shade_t;

    typedef struct packed {
        pixel_t px;
        logic   typed;
        shade_t want;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [COL_W-1:0]     column;
    logic [ROW_W-1:0]     row;
    logic [WALL_W-1:0]    wall_height;
    logic [FACE_W-1:0]    face;
    logic [TCOL_W-1:0]    tex_col;
    logic [TDIM_W-1:0]    tex_width;
    logic [TDIM_W-1:0]    tex_height;
    logic                 out_valid;
    logic                 out_ready;
    logic [ADDR_W-1:0]    pixel_address;
    logic [REGION_W-1:0]  region;
    logic [COLOR_W-1:0]   flat_color;
    logic [TEXEL_W-1:0]   texel_index;
    logic [FACE_W-1:0]    texture_face;

    rcps_cfg_t shadow_cfg;
    shade_t    shade_queue[$];
    bit        idle_on;
    int        mismatch_count;
    int        pixels_sent;
    int        results_checked;
    int        settings_count;
    int        cycle_count;

    // Directed pixels, run with the reset register values
    // (base 0, stride 2048, 4 bytes per pixel, both colors 0)
    directed_row_t directed_rows[20] = '{
        // top-left corner, ceiling
        '{'{12'd0, 9'd0, 16'd100, 2'd0, 12'd0, 13'd64, 13'd64}, 1'b1,
          '{32'd0, REGION_CEILING, 32'd0, 24'd0, 2'd0}},
        // bottom-right corner, floor
        '{'{12'd4095, 9'd511, 16'd100, 2'd3, 12'd0, 13'd64, 13'd64}, 1'b1,
          '{32'd1062908, REGION_FLOOR, 32'd0, 24'd0, 2'd3}},
        // zero wall height: one wall row, last texture row
        '{'{12'd0, 9'd257, 16'd0, 2'd1, 12'd5, 13'd64, 13'd64}, 1'b1,
          '{32'd526336, REGION_WALL, 32'd0, 24'd4037, 2'd1}},
        '{'{12'd0, 9'd256, 16'd0, 2'd1, 12'd5, 13'd64, 13'd64}, 1'b0, '0},
        '{'{12'd0, 9'd258, 16'd0, 2'd1, 12'd5, 13'd64, 13'd64}, 1'b0, '0},
        // zero texture height: texture row stays at 0
        '{'{12'd0, 9'd256, 16'd100, 2'd2, 12'd4095, 13'd4096, 13'd0}, 1'b1,
          '{32'd524288, REGION_WALL, 32'd0, 24'd4095, 2'd2}},
        // edges of a 100-pixel wall, last row clamps the texture row
        '{'{12'd1, 9'd206, 16'd100, 2'd0, 12'd3, 13'd100, 13'd64}, 1'b0, '0},
        '{'{12'd1, 9'd207, 16'd100, 2'd1, 12'd3, 13'd100, 13'd64}, 1'b0, '0},
        '{'{12'd1, 9'd307, 16'd100, 2'd2, 12'd0, 13'd100, 13'd64}, 1'b0, '0},
        '{'{12'd1, 9'd308, 16'd100, 2'd3, 12'd0, 13'd100, 13'd64}, 1'b0, '0},
        // tallest wall covers the whole column
        '{'{12'd2, 9'd0, 16'd65535, 2'd3, 12'd4095, 13'd8191, 13'd8191}, 1'b0, '0},
        '{'{12'd2, 9'd511, 16'd65535, 2'd3, 12'd4095, 13'd8191, 13'd8191}, 1'b0, '0},
        // wall of exactly screen height, and one short of it
        '{'{12'd3, 9'd0, 16'd512, 2'd0, 12'd7, 13'd32, 13'd32}, 1'b0, '0},
        '{'{12'd3, 9'd1, 16'd511, 2'd1, 12'd7, 13'd32, 13'd32}, 1'b0, '0},
        '{'{12'd3, 9'd2, 16'd511, 2'd2, 12'd7, 13'd32, 13'd32}, 1'b0, '0},
        // one-pixel wall, second row clamps
        '{'{12'd4, 9'd258, 16'd1, 2'd1, 12'd0, 13'd16, 13'd16}, 1'b0, '0},
        // texel index wraps past 24 bits
        '{'{12'd5, 9'd257, 16'd0, 2'd2, 12'd4095, 13'd8191, 13'd8191}, 1'b0, '0},
        // zero texture width
        '{'{12'd6, 9'd300, 16'd1000, 2'd1, 12'd100, 13'd0, 13'd4096}, 1'b0, '0},
        '{'{12'd7, 9'd100, 16'd200, 2'd0, 12'd2048, 13'd4095, 13'd4095}, 1'b0, '0},
        '{'{12'd4095, 9'd511, 16'd0, 2'd3, 12'd4095, 13'd8191, 13'd1}, 1'b0, '0}
    };

    raycast_column_pixel_shader_core #(
        .SCREEN_HEIGHT (SCREEN_H)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .column        (column),
        .row           (row),
        .wall_height   (wall_height),
        .face          (face),
        .tex_col       (tex_col),
        .tex_width     (tex_width),
        .tex_height    (tex_height),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_address (pixel_address),
        .region        (region),
        .flat_color    (flat_color),
        .texel_index   (texel_index),
        .texture_face  (texture_face)
    );

    // Clock, 4 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, shade_queue.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Shade one pixel: region, flat color, texel index and address
    function automatic shade_t shade_pixel(pixel_t px, rcps_cfg_t cfg);
        shade_t      s;
        longint      half_w;
        longint      c;
        longint      start;
        longint      r;
        longint      d;
        logic [63:0] ty;
        logic [63:0] tmp;
        half_w = longint'(px.wall_height >> 1);
        c      = HALF_H - half_w;
        r      = longint'(px.row);
        s      = '0;
        s.texture_face = px.face;
        if (c > 0 && r <= c)
        begin
            s.region     = REGION_CEILING;
            s.flat_color = cfg.ceiling_color;
        end
        else
        begin
            start = (c > 0) ? c + 1 : 0;
            if (r <= start + longint'(px.wall_height))
            begin
                d = r + half_w - HALF_H;
                if (d < 0)
                    d = 0;
                // texture row, exact integer divide, clamped to the last row
                if (px.tex_height == '0)
                    ty = '0;
                else if (px.wall_height == '0)
                    ty = px.tex_height - 1;
                else
                begin
                    ty = d * px.tex_height / px.wall_height;
                    if (ty >= px.tex_height)
                        ty = px.tex_height - 1;
                end
                tmp           = px.tex_width * ty + px.tex_col;
                s.region      = REGION_WALL;
                s.texel_index = tmp[TEXEL_W-1:0];
            end
            else
            begin
                s.region     = REGION_FLOOR;
                s.flat_color = cfg.floor_color;
            end
        end
        tmp = cfg.frame_base + px.row * cfg.line_stride + px.column * (cfg.pixel_bits >> 3);
        s.pixel_address = tmp[ADDR_W-1:0];
        return s;
    endfunction

    // Random column parameters; wall and texture sizes skewed toward sane values
    function automatic pixel_t random_column();
        pixel_t px;
        px.column = COL_W'($urandom_range(0, 4095));
        px.row    = ROW_W'($urandom_range(0, 511));
        px.face   = FACE_W'($urandom_range(0, 3));
        px.tex_col = TCOL_W'($urandom_range(0, 4095));
        case ($urandom_range(0, 9))
            0:       px.wall_height = WALL_W'($urandom_range(0, 3));
            7:       px.wall_height = WALL_W'($urandom_range(1, 65535));
            8:       px.wall_height = WALL_W'(65535 - $urandom_range(0, 3));
            9:       px.wall_height = WALL_W'($urandom_range(500, 520));
            default: px.wall_height = WALL_W'($urandom_range(1, 1024));
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            px.tex_width  = TDIM_W'($urandom_range(0, 8191));
            px.tex_height = TDIM_W'($urandom_range(0, 8191));
        end
        else
        begin
            px.tex_width  = TDIM_W'(1 << $urandom_range(0, 12));
            px.tex_height = TDIM_W'(1 << $urandom_range(0, 12));
        end
        return px;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
    endtask

    // Send one pixel beat; queue its expected shade once accepted
    task automatic send_pixel(pixel_t px, logic typed, shade_t want);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        column      = px.column;
        row         = px.row;
        wall_height = px.wall_height;
        face        = px.face;
        tex_col     = px.tex_col;
        tex_width   = px.tex_width;
        tex_height  = px.tex_height;
        in_valid    = 1'b1;
        do @(posedge clk); while (!in_ready);
        shade_queue.push_back(typed ? want : shade_pixel(px, shadow_cfg));
        pixels_sent++;
    endtask

    // Drop valid and hold off until every expected shade has come out
    task automatic drain_pipe();
        @(negedge clk);
        in_valid = 1'b0;
        while (shade_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_CEILING_COLOR: shadow_cfg.ceiling_color = data;
            REG_FLOOR_COLOR:   shadow_cfg.floor_color   = data;
            REG_FRAME_BASE:    shadow_cfg.frame_base    = data;
            REG_LINE_STRIDE:   shadow_cfg.line_stride   = data[STRIDE_W-1:0];
            REG_PIXEL_BITS:    shadow_cfg.pixel_bits    = data[PBITS_W-1:0];
            default: ;  // no register at this index
        endcase
    endtask

    task automatic apply_settings(logic [31:0] ceil_c, logic [31:0] floor_c,
                                  logic [31:0] base, logic [31:0] stride,
                                  logic [31:0] pbits);
        write_reg(REG_CEILING_COLOR, ceil_c);
        write_reg(REG_FLOOR_COLOR, floor_c);
        write_reg(REG_FRAME_BASE, base);
        write_reg(REG_LINE_STRIDE, stride);
        write_reg(REG_PIXEL_BITS, pbits);
        @(negedge clk);
        cfg_valid = 1'b0;
        settings_count++;
    endtask

    // Runs of consecutive rows down one column, with the odd noise run
    task automatic run_phase(int target);
        pixel_t px;
        int     sent_here;
        int     run_len;
        bit     noise;
        sent_here = 0;
        while (sent_here < target)
        begin
            px      = random_column();
            noise   = ($urandom_range(0, 7) == 0);
            run_len = $urandom_range(1, 48);
            // last run of the phase is cut to the target
            if (run_len > target - sent_here)
                run_len = target - sent_here;
            repeat (run_len)
            begin
                if (noise)
                    px = random_column();
                send_pixel(px, 1'b0, '0);
                px.row = px.row + 1'b1;
                sent_here++;
            end
        end
        drain_pipe();
    endtask

    // Result side: random stall before each beat, then check it
    initial
    begin : result_sink
        int     stall;
        shade_t got;
        shade_t want;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            got = '{pixel_address, region, flat_color, texel_index, texture_face};
            results_checked++;
            if (shade_queue.size() == 0)
                note_mismatch("unexpected beat, address", '0, got.pixel_address);
            else
            begin
                want = shade_queue.pop_front();
                if (got.pixel_address !== want.pixel_address)
                    note_mismatch("pixel_address", want.pixel_address, got.pixel_address);
                if (got.region !== want.region)
                    note_mismatch("region", 32'(want.region), 32'(got.region));
                if (got.flat_color !== want.flat_color)
                    note_mismatch("flat_color", want.flat_color, got.flat_color);
                if (got.texel_index !== want.texel_index)
                    note_mismatch("texel_index", 32'(want.texel_index), 32'(got.texel_index));
                if (got.texture_face !== want.texture_face)
                    note_mismatch("texture_face", 32'(want.texture_face),
                                  32'(got.texture_face));
            end
        end
    end

    // Main sequence
    initial
    begin : stimulus
        int phase;
        mismatch_count  = 0;
        pixels_sent     = 0;
        results_checked = 0;
        settings_count  = 0;
        cycle_count     = 0;
        idle_on         = 1'b1;
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        column          = '0;
        row             = '0;
        wall_height     = '0;
        face            = '0;
        tex_col         = '0;
        tex_width       = '0;
        tex_height      = '0;
        shadow_cfg      = '0;
        shadow_cfg.line_stride = LINE_STRIDE_RST;
        shadow_cfg.pixel_bits  = PIXEL_BITS_RST;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed pixels against the reset register values
        foreach (directed_rows[i])
            send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].want);
        drain_pipe();

        // random runs under several register settings
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            idle_on = (phase % 3 != 1);
            case (phase)
                0:
                begin
                    // write to an empty index must change nothing
                    write_reg(REG_UNUSED, $urandom);
                    apply_settings('1, '1, '1, '1, '1);
                end
                1:       apply_settings('0, '0, '0, '0, '0);
                2:       apply_settings('0, '1, '0, 32'd1, 32'd8);
                default: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            run_phase(PHASE_PIXELS);
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d pixels under %0d register settings, %0d results checked",
                 pixels_sent, settings_count + 1, results_checked);
        $display("mismatches: %0d, results still pending: %0d",
                 mismatch_count, shade_queue.size());
        if (mismatch_count == 0 && shade_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/rcps_pkg.sv
rtl/core/rcps_classify.sv
rtl/core/rcps_div_step.sv
rtl/core/rcps_texel.sv
rtl/core/raycast_column_pixel_shader_core.sv
sim/testbench.sv
